@@ rtl/dlaq_pkg.sv @@
// ----------------------------------------------------------------------------
// dlaq_pkg: shared types and constants of the delta-list alarm queue
// Transaction payload structs, input kind codes and result kind codes.
// ----------------------------------------------------------------------------
package dlaq_pkg;

    localparam int DELTA_W = 21;
    localparam int TPS_W   = 14;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic RES_INSERT = 1'b0;
    localparam logic RES_EXPIRE = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] delay_ms;
        logic [3:0]  slot_id;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] slot_index;
        logic       status;
        logic       was_canceled;
        logic       last;
    } out_item_t;

endpackage

@@ rtl/dlaq_ram.sv @@
// ----------------------------------------------------------------------------
// dlaq_ram: generic single-port-write RAM with registered read
// One write port and one read port; read data is registered and appears in the cycle after its address.
// ----------------------------------------------------------------------------
module dlaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/dlaq_scale.sv @@
// ----------------------------------------------------------------------------
// dlaq_scale: millisecond to tick conversion
// Computes floor(ms * tps / 1000) as a multiply followed by a reciprocal
// multiply and one correction step, one register after each product.
// ----------------------------------------------------------------------------
module dlaq_scale
    import dlaq_pkg::*;
(
    input  logic               clk,
    input  logic [15:0]        ms,
    input  logic [TPS_W-1:0]   tps,
    output logic [DELTA_W-1:0] ticks
);

    // The product is below 2^30; ceil(2^40 / 1000) gives a quotient that is
    // at most one too large there, fixed by one compare.
    localparam logic [30:0] RECIP = 31'd1099511628;

    logic [29:0] prod_reg;
    logic [60:0] qprod_reg;
    logic [29:0] prod_d_reg;
    logic [20:0] q;
    logic [30:0] back;

    always_ff @(posedge clk)
    begin
        prod_reg   <= 30'(ms * tps);
        qprod_reg  <= 61'(prod_reg * RECIP);
        prod_d_reg <= prod_reg;
    end

    always_comb
    begin
        q    = qprod_reg[60:40];
        back = 31'(q * 11'd1000);
        if (back > {1'b0, prod_d_reg})
        begin
            ticks = q - 21'd1;
        end
        else
        begin
            ticks = q;
        end
    end

endmodule

@@ rtl/delta_list_alarm_queue.sv @@
// ----------------------------------------------------------------------------
// delta_list_alarm_queue: delta-encoded alarm list over a slot pool
// Inserts, cancels and ticks alarms kept in a list sorted by expiry.
// ----------------------------------------------------------------------------
// Channel   Signals                        Direction
// in        in_valid, in_ready, in_data    item in
// out       out_valid, out_ready, out_data result out
// cfg       cfg_valid, cfg_ready, cfg_data ticks_per_second write
//
// Each insert list step reads the delta and next RAMs through their
// registered read port. A removed alarm is held one step before it is
// shown, so that its last flag is known. Each result waits in the output
// register until taken, which stalls the tick walk. Reset clears the busy
// and live bits, the list head and the control state, sets ticks_per_second
// to 1000 and does not clear the RAMs.
// ----------------------------------------------------------------------------
module delta_list_alarm_queue
    import dlaq_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [TPS_W-1:0] cfg_data
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int PW = SW + 1;
    localparam int MAX_RESULTS = 16;
    localparam logic [PW-1:0] NIL = PW'(NUM_SLOTS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCALE, ST_WREAD, ST_WCMP, ST_LINK, ST_ACK,
        ST_TREAD, ST_TDEC, ST_TCHK, ST_TOUT
    } state_t;

    state_t state_reg;
    logic [NUM_SLOTS-1:0] busy_reg, live_reg;
    logic [PW-1:0] head_reg, walk_reg, prev_reg;
    logic [SW-1:0] free_reg;
    logic [DELTA_W-1:0] dt_reg;
    logic [TPS_W-1:0] tps_reg;
    logic [15:0] ms_reg;
    logic [2:0] wait_reg;
    logic [PW-1:0] steps_reg;
    logic [4:0] nres_reg;
    logic out_valid_reg;
    out_item_t out_reg;
    logic hold_valid_reg;
    out_item_t hold_reg;

    // RAM ports
    logic d_we, n_we;
    logic [SW-1:0] d_waddr, n_waddr, raddr;
    logic [DELTA_W-1:0] d_wdata, d_rdata;
    logic [PW-1:0] n_wdata, n_rdata;
    logic [DELTA_W-1:0] ticks;

    // Lowest free slot: priority search over busy bits.
    logic [SW-1:0] free_idx;
    logic          free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    dlaq_scale u_scale (.clk(clk), .ms(ms_reg), .tps(tps_reg), .ticks(ticks));

    dlaq_ram #(.WIDTH(DELTA_W), .DEPTH(NUM_SLOTS)) u_delta (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(raddr), .rdata(d_rdata)
    );
    dlaq_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS)) u_next (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(raddr), .rdata(n_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // The tick walk stops at an empty list, a nonzero head or the result cap.
    logic tick_done;
    assign tick_done = (head_reg == NIL) || (d_rdata != '0)
                       || (nres_reg == 5'(MAX_RESULTS));

    logic out_load;
    assign out_load = (state_reg == ST_IDLE && in_valid && in_ready
                       && in_data.kind == KIND_INSERT && !free_any)
                      || (state_reg == ST_ACK)
                      || (state_reg == ST_TOUT && hold_valid_reg && out_free);

    // Read address follows the walk pointer or the head.
    always_comb
    begin
        raddr = (state_reg == ST_IDLE || state_reg == ST_TOUT
                 || state_reg == ST_TCHK || state_reg == ST_TREAD
                 || state_reg == ST_TDEC) ? head_reg[SW-1:0] : walk_reg[SW-1:0];
        if (state_reg == ST_SCALE || state_reg == ST_LINK)
        begin
            raddr = walk_reg[SW-1:0];
        end
    end

    // RAM writes
    always_comb
    begin
        d_we = 1'b0; d_waddr = walk_reg[SW-1:0]; d_wdata = d_rdata - dt_reg;
        n_we = 1'b0; n_waddr = free_reg; n_wdata = walk_reg;
        case (state_reg)
            ST_WCMP:
            begin
                if (walk_reg != NIL && steps_reg != NIL && d_rdata > dt_reg)
                begin
                    d_we = 1'b1;
                end
            end
            ST_LINK:
            begin
                // Write the new entry; prev's next pointer is written in ST_ACK.
                d_we = 1'b1; d_waddr = free_reg; d_wdata = dt_reg;
                n_we = 1'b1;
            end
            ST_ACK:
            begin
                if (prev_reg != NIL)
                begin
                    n_we = 1'b1; n_waddr = prev_reg[SW-1:0]; n_wdata = PW'(free_reg);
                end
            end
            ST_TDEC:
            begin
                if (d_rdata != '0)
                begin
                    d_we = 1'b1; d_waddr = head_reg[SW-1:0];
                    d_wdata = d_rdata - DELTA_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            live_reg      <= '0;
            head_reg      <= NIL;
            tps_reg       <= TPS_W'(1000);
            out_valid_reg <= 1'b0;
            walk_reg <= NIL; prev_reg <= NIL; free_reg <= '0; dt_reg <= '0;
            ms_reg <= '0; wait_reg <= '0; steps_reg <= '0; nres_reg <= '0;
            out_reg <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tps_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        case (in_data.kind)
                            KIND_INSERT:
                            begin
                                if (free_any)
                                begin
                                    free_reg  <= free_idx;
                                    ms_reg    <= in_data.delay_ms;
                                    wait_reg  <= '0;
                                    state_reg <= ST_SCALE;
                                end
                                else
                                begin
                                    out_reg <= '{RES_INSERT, 4'd0, 1'b1, 1'b0, 1'b1};
                                end
                            end
                            KIND_CANCEL:
                            begin
                                if (32'(in_data.slot_id) < NUM_SLOTS)
                                begin
                                    live_reg[SW'(in_data.slot_id)] <= 1'b0;
                                end
                            end
                            KIND_TICK:
                            begin
                                if (head_reg != NIL)
                                begin
                                    nres_reg  <= '0;
                                    state_reg <= ST_TREAD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCALE:
                begin
                    wait_reg <= wait_reg + 3'd1;
                    walk_reg <= head_reg;
                    prev_reg <= NIL;
                    steps_reg <= '0;
                    if (wait_reg == 3'd3)
                    begin
                        dt_reg    <= ticks;
                        state_reg <= ST_WREAD;
                    end
                end
                ST_WREAD:
                begin
                    state_reg <= ST_WCMP;
                end
                ST_WCMP:
                begin
                    if (walk_reg == NIL || steps_reg == NIL || d_rdata > dt_reg)
                    begin
                        state_reg <= ST_LINK;
                    end
                    else
                    begin
                        dt_reg    <= dt_reg - d_rdata;
                        prev_reg  <= walk_reg;
                        walk_reg  <= n_rdata;
                        steps_reg <= steps_reg + PW'(1);
                        state_reg <= ST_WREAD;
                    end
                end
                ST_LINK:
                begin
                    if (prev_reg == NIL)
                    begin
                        head_reg <= PW'(free_reg);
                    end
                    busy_reg[free_reg] <= 1'b1;
                    live_reg[free_reg] <= 1'b1;
                    state_reg <= ST_ACK;
                end
                ST_ACK:
                begin
                    out_reg   <= '{RES_INSERT, 4'(free_reg), 1'b0, 1'b0, 1'b1};
                    state_reg <= ST_IDLE;
                end
                ST_TREAD:
                begin
                    state_reg <= ST_TDEC;
                end
                ST_TDEC:
                begin
                    state_reg <= ST_TCHK;
                end
                ST_TCHK:
                begin
                    // Head read issued in this state is valid in ST_TOUT.
                    state_reg <= ST_TOUT;
                end
                ST_TOUT:
                begin
                    if (tick_done)
                    begin
                        if (!hold_valid_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            out_reg <= '{hold_reg.result_kind, hold_reg.slot_index,
                                         hold_reg.status, hold_reg.was_canceled, 1'b1};
                            hold_valid_reg <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    else if (!hold_valid_reg || out_free)
                    begin
                        // Another removal follows, so the held one is not last.
                        if (hold_valid_reg)
                        begin
                            out_reg <= hold_reg;
                        end
                        hold_reg <= '{RES_EXPIRE, 4'(head_reg[SW-1:0]), 1'b0,
                                      !live_reg[head_reg[SW-1:0]], 1'b0};
                        hold_valid_reg <= 1'b1;
                        busy_reg[head_reg[SW-1:0]] <= 1'b0;
                        live_reg[head_reg[SW-1:0]] <= 1'b0;
                        head_reg  <= n_rdata;
                        nres_reg  <= nres_reg + 5'd1;
                        state_reg <= ST_TCHK;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RES_INSERT |-> out_data.last)
        else $error("insert acknowledgment without last");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == RES_EXPIRE |-> !out_data.status)
        else $error("expiry with nonzero status");

endmodule
